[rtl/sldf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sldf_pkg
// Types and constants shared by the sync/length word deframer.
// ----------------------------------------------------------------------------
package sldf_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hFA;
    localparam logic [7:0] SYNC_SECOND = 8'hF3;

    localparam int MAX_WORDS_DEF = 64;
    localparam int CFG_W         = 7;
    localparam int INDEX_W       = 6;
    localparam int TOTAL_W       = 7;
    localparam int COUNT_W       = 32;
    localparam int WORD_W        = 64;
    localparam int BYTE_W        = 8;
    localparam int POS_W         = 3;

    localparam logic [CFG_W-1:0] MAX_WORDS_RST = 7'd64;

    localparam logic [POS_W-1:0] COUNT_LAST_POS = 3'd3;
    localparam logic [POS_W-1:0] WORD_LAST_POS  = 3'd7;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_COUNT,
        PH_DATA
    } t_phase;

    typedef enum logic {
        KIND_DATA      = 1'b0,
        KIND_COUNT_ERR = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [INDEX_W-1:0]  word_index;
        logic [WORD_W-1:0]   data_word;
        logic [COUNT_W-1:0]  frame_count;
        logic                last;
    } t_result;

endpackage : sldf_pkg
`default_nettype wire

[rtl/sldf_out_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sldf_out_buf
// Two-entry output stage: an output register with a skid register behind it,
// so the deframer keeps taking bytes while a result waits downstream.
// ----------------------------------------------------------------------------
module sldf_out_buf
    import sldf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_take;

    assign w_take  = r_out_valid & i_ready;
    assign o_space = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // Input side is stalled while the skid register is occupied.
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_take) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule : sldf_out_buf
`default_nettype wire

[rtl/sync_length_word_deframer_core.sv]
`default_nettype none
// A completed result goes into the output register, or the skid register if full.
// Throughput: one byte per cycle; the per-byte shift and compare in the phase
// logic sets this, and ready drops only while both output registers hold words.
// Reset: synchronous, active low; returns to sync hunting, clears the counters,
// sets max_words to 64 and empties the output stage.
// ----------------------------------------------------------------------------
// sync_length_word_deframer_core
// Hunts for the two sync bytes, reads a big-endian word count and emits the
// following 64-bit words, a count error above the limit, or nothing for zero.
// ----------------------------------------------------------------------------
module sync_length_word_deframer_core
    import sldf_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [BYTE_W-1:0]  i_rx_byte,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_kind,
    output logic [INDEX_W-1:0]      o_word_index,
    output logic [WORD_W-1:0]       o_data_word,
    output logic [COUNT_W-1:0]      o_frame_count,
    output logic                    o_last
);

    localparam logic [CFG_W-1:0] LIMIT_CAP = CFG_W'(MAX_WORDS);

    t_phase              r_phase, n_phase;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [INDEX_W-1:0]  r_counter, n_counter;
    logic [CFG_W-1:0]    r_max_words;

    logic                w_accept;
    logic [CFG_W-1:0]    w_limit;
    logic [COUNT_W-1:0]  w_count_next;
    logic [WORD_W-1:0]   w_word_next;
    logic                w_over;
    logic                w_zero;
    logic                w_fin;
    logic                w_push;
    t_result             w_res;
    t_result             w_out;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_words <= MAX_WORDS_RST;
        end else if (i_cfg_valid) begin
            r_max_words <= i_cfg_data;
        end
    end

    assign w_limit      = (r_max_words > LIMIT_CAP) ? LIMIT_CAP : r_max_words;
    assign w_count_next = {r_count[COUNT_W-BYTE_W-1:0], i_rx_byte};
    assign w_word_next  = {r_word[WORD_W-BYTE_W-1:0], i_rx_byte};
    assign w_over       = w_count_next > COUNT_W'(w_limit);
    assign w_zero       = w_count_next == '0;
    assign w_fin        = ({1'b0, r_counter} + TOTAL_W'(1)) >= r_total;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == SYNC_FIRST) n_phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    n_phase = (i_rx_byte == SYNC_SECOND) ? PH_COUNT : PH_HUNT;
                end
                PH_COUNT: begin
                    if (r_pos == COUNT_LAST_POS) begin
                        n_phase = (w_over || w_zero) ? PH_HUNT : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (r_pos == WORD_LAST_POS && w_fin) n_phase = PH_HUNT;
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // Datapath and result.
    always_comb begin
        n_pos              = r_pos;
        n_count            = r_count;
        n_word             = r_word;
        n_total            = r_total;
        n_counter          = r_counter;
        w_push             = 1'b0;
        w_res.kind         = KIND_DATA;
        w_res.word_index   = r_counter;
        w_res.data_word    = w_word_next;
        w_res.frame_count  = r_count;
        w_res.last         = w_fin;
        if (w_accept) begin
            case (r_phase)
                PH_HUNT: begin
                end
                PH_SYNC2: begin
                    n_pos     = '0;
                    n_counter = '0;
                    if (i_rx_byte == SYNC_SECOND) n_count = '0;
                end
                PH_COUNT: begin
                    n_count = w_count_next;
                    if (r_pos != COUNT_LAST_POS) begin
                        n_pos = r_pos + POS_W'(1);
                    end else begin
                        n_pos     = '0;
                        n_counter = '0;
                        if (w_over) begin
                            w_push            = 1'b1;
                            w_res.kind        = KIND_COUNT_ERR;
                            w_res.word_index  = '0;
                            w_res.data_word   = '0;
                            w_res.frame_count = w_count_next;
                            w_res.last        = 1'b1;
                        end else if (!w_zero) begin
                            // Not above the limit, so the count fits the total.
                            n_total = w_count_next[TOTAL_W-1:0];
                        end
                    end
                end
                PH_DATA: begin
                    n_word = w_word_next;
                    if (r_pos != WORD_LAST_POS) begin
                        n_pos = r_pos + POS_W'(1);
                    end else begin
                        w_push    = 1'b1;
                        n_pos     = '0;
                        n_counter = w_fin ? '0 : r_counter + INDEX_W'(1);
                    end
                end
                default: begin
                    n_pos     = '0;
                    n_counter = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_pos     <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_counter <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_total   <= n_total;
            r_counter <= n_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    sldf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out)
    );

    assign o_kind        = w_out.kind;
    assign o_word_index  = w_out.word_index;
    assign o_data_word   = w_out.data_word;
    assign o_frame_count = w_out.frame_count;
    assign o_last        = w_out.last;

    // A stalled input means both output registers are full.
    a_stall_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with an empty output register");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (o_last && o_data_word == '0 && o_word_index == '0))
        else $error("count error word is malformed");

    a_data_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_total != '0 && r_total <= LIMIT_CAP))
        else $error("data phase with a word total outside the limit");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> ({1'b0, r_counter} < r_total))
        else $error("word counter ran past the frame total");

endmodule : sync_length_word_deframer_core
`default_nettype wire
